// ----- hdl/dpo_pkg.sv -----
// ----------------------------------------------------------------------------
// dpo_pkg: shared types and constants for the door passage occupancy block
// Holds the input and result word layouts, the door command codes, the door
// state codes seen on the result word and the default sizes.
// ----------------------------------------------------------------------------
package dpo_pkg;

    // Default sizes for the top level parameters.
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int TIMER_WIDTH_DEF = 20;

    // Timeout loaded at reset, in ticks.
    localparam int TIMEOUT_RESET = 10000;

    // Width of the occupant count on the result word.
    localparam int OUT_COUNT_WIDTH = 16;

    // Door command codes.
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_OPEN  = 2'd1;
    localparam logic [1:0] CMD_CLOSE = 2'd2;

    // Door state codes as reported on the result word.
    localparam logic [2:0] DS_CLOSED   = 3'd0;
    localparam logic [2:0] DS_OPEN_IN  = 3'd1;
    localparam logic [2:0] DS_OPEN_OUT = 3'd2;
    localparam logic [2:0] DS_TO_EXIT  = 3'd3;
    localparam logic [2:0] DS_TO_ENTER = 3'd4;
    localparam logic [2:0] DS_EXITING  = 3'd5;
    localparam logic [2:0] DS_ENTERING = 3'd6;

    // One tick of sensor levels.
    typedef struct packed {
        logic button_pressed;
        logic inside_sensor;
        logic outside_sensor;
        logic remote_open;
    } t_in_word;

    // One result per tick.
    typedef struct packed {
        logic [1:0]                        door_command;
        logic                              light_on;
        logic signed [OUT_COUNT_WIDTH-1:0] occupant_count_out;
        logic [2:0]                        door_state;
    } t_out_word;

endpackage

// ----- hdl/door_passage_occupancy_fsm.sv -----
// ----------------------------------------------------------------------------
// door_passage_occupancy_fsm: door controller with bidirectional people count
// A result word is registered and shows on the output register in the cycle
// after its input word is accepted. Throughput: one word per cycle while the
// consumer takes each result, set by the single registered next-state pass.
// Reset (i_rst_n low, synchronous): door closed, timer and count zero,
// timeout back to 10000 ticks, no result pending.
// ----------------------------------------------------------------------------
module door_passage_occupancy_fsm #(
    parameter int COUNT_WIDTH = dpo_pkg::COUNT_WIDTH_DEF,
    parameter int TIMER_WIDTH = dpo_pkg::TIMER_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Input channel: one word per millisecond tick.
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  dpo_pkg::t_in_word      i_in_word,
    // Result channel: one word per accepted input word.
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output dpo_pkg::t_out_word     o_out_word,
    // Timeout register write port.
    input  logic                   i_cfg_we,
    input  logic [TIMER_WIDTH-1:0] i_cfg_data
);

    // Door and passage states. Code 7 is never entered; if it were, the
    // machine would hold it with no command until a remote open.
    typedef enum logic [2:0] {
        ST_CLOSED   = 3'd0,
        ST_OPEN_IN  = 3'd1,
        ST_OPEN_OUT = 3'd2,
        ST_TO_EXIT  = 3'd3,
        ST_TO_ENTER = 3'd4,
        ST_EXITING  = 3'd5,
        ST_ENTERING = 3'd6
    } t_state;

    // Saturation limits of the signed occupant count.
    localparam logic signed [COUNT_WIDTH-1:0] CountMax = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
    localparam logic signed [COUNT_WIDTH-1:0] CountMin = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

    t_state                          r_state,   n_state;
    logic [TIMER_WIDTH-1:0]          r_elapsed, n_elapsed;
    logic signed [COUNT_WIDTH-1:0]   r_count,   n_count;
    logic [TIMER_WIDTH-1:0]          r_timeout;
    logic                            r_out_valid;
    dpo_pkg::t_out_word              r_out_word, n_out_word;

    logic                            accept;
    logic [1:0]                      cmd;
    logic [TIMER_WIDTH-1:0]          elapsed_inc;
    logic [TIMER_WIDTH-1:0]          elapsed_sat;
    logic                            timed_out;

    // The result register frees up in the same cycle its word is taken, so
    // a new tick is accepted every cycle unless the consumer stalls.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    // The open timer counts up and saturates at the timeout. The increment
    // is only used while the timer is below the timeout, so it cannot wrap.
    // The door is forced closed once the advanced count has reached the
    // timeout, which also covers a timeout of zero.
    assign elapsed_inc = r_elapsed + TIMER_WIDTH'(1);
    assign elapsed_sat = (r_elapsed < r_timeout) ? elapsed_inc : r_timeout;
    assign timed_out   = (elapsed_sat >= r_timeout);

    always_comb begin
        n_state   = r_state;
        n_elapsed = r_elapsed;
        n_count   = r_count;
        cmd       = dpo_pkg::CMD_NONE;

        if (i_in_word.remote_open) begin
            // The partner already opened the door: just track it and restart
            // the timer. This beats every other event of the tick.
            n_state   = ST_OPEN_OUT;
            n_elapsed = '0;
        end else if (r_state == ST_CLOSED) begin
            if (i_in_word.button_pressed) begin
                n_state   = ST_OPEN_IN;
                n_elapsed = '0;
                cmd       = dpo_pkg::CMD_OPEN;
            end
        end else if (r_state <= ST_ENTERING) begin
            n_elapsed = elapsed_sat;
            if (timed_out) begin
                n_state = ST_CLOSED;
                cmd     = dpo_pkg::CMD_CLOSE;
            end else begin
                // The order in which the two sensors fire tells an exit
                // from an entry.
                case (r_state)
                    ST_OPEN_IN: begin
                        if (i_in_word.inside_sensor) begin
                            n_state = ST_TO_EXIT;
                        end else if (i_in_word.outside_sensor) begin
                            n_state = ST_ENTERING;
                        end
                    end
                    ST_OPEN_OUT: begin
                        if (i_in_word.outside_sensor) begin
                            n_state = ST_TO_ENTER;
                        end else if (i_in_word.inside_sensor) begin
                            n_state = ST_TO_EXIT;
                        end
                    end
                    ST_TO_EXIT: begin
                        if (i_in_word.outside_sensor) begin
                            n_state = ST_EXITING;
                        end else if (!i_in_word.inside_sensor) begin
                            n_state = ST_OPEN_IN;
                        end
                    end
                    ST_TO_ENTER: begin
                        if (i_in_word.inside_sensor) begin
                            n_state = ST_ENTERING;
                        end else if (!i_in_word.outside_sensor) begin
                            n_state = ST_OPEN_OUT;
                        end
                    end
                    ST_EXITING: begin
                        if (!i_in_word.inside_sensor) begin
                            // Person has left: count down and close.
                            if (r_count > CountMin) begin
                                n_count = r_count - COUNT_WIDTH'(1);
                            end
                            n_state = ST_CLOSED;
                            cmd     = dpo_pkg::CMD_CLOSE;
                        end else if (!i_in_word.outside_sensor) begin
                            n_state = ST_TO_EXIT;
                        end
                    end
                    ST_ENTERING: begin
                        if (!i_in_word.outside_sensor) begin
                            // Person has come in: count up and close.
                            if (r_count < CountMax) begin
                                n_count = r_count + COUNT_WIDTH'(1);
                            end
                            n_state = ST_CLOSED;
                            cmd     = dpo_pkg::CMD_CLOSE;
                        end else if (!i_in_word.inside_sensor) begin
                            n_state = ST_TO_ENTER;
                        end
                    end
                    default: begin
                        n_state = r_state;
                    end
                endcase
            end
        end

        // The light follows the count held before this tick.
        n_out_word.door_command       = cmd;
        n_out_word.light_on           = (r_count > 0);
        n_out_word.occupant_count_out = dpo_pkg::OUT_COUNT_WIDTH'(n_count);
        n_out_word.door_state         = n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLOSED;
            r_elapsed   <= '0;
            r_count     <= '0;
            r_timeout   <= TIMER_WIDTH'(dpo_pkg::TIMEOUT_RESET);
            r_out_valid <= 1'b0;
            r_out_word  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_data;
            end
            if (accept) begin
                r_state     <= n_state;
                r_elapsed   <= n_elapsed;
                r_count     <= n_count;
                r_out_word  <= n_out_word;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ----- hdl/dpo_checker.sv -----
// ----------------------------------------------------------------------------
// dpo_checker: port-level checks for the door passage occupancy block
// Watches the handshakes and the result words and flags inconsistent ones.
// ----------------------------------------------------------------------------
module dpo_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input dpo_pkg::t_out_word o_out_word
);

    // A stalled result word stays put until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed or dropped while stalled");

    // With nothing pending the block must take a new word.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input not ready with an empty result register");

    // An open command only comes with the opened-from-inside state.
    a_open_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.door_command == dpo_pkg::CMD_OPEN
        |-> o_out_word.door_state == dpo_pkg::DS_OPEN_IN)
        else $error("open command without the opened-from-inside state");

    // Every close command leaves the door closed.
    a_close_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.door_command == dpo_pkg::CMD_CLOSE
        |-> o_out_word.door_state == dpo_pkg::DS_CLOSED)
        else $error("close command without the closed state");

    // The command field never carries the unused code.
    a_cmd_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_word.door_command == dpo_pkg::CMD_NONE
                     || o_out_word.door_command == dpo_pkg::CMD_OPEN
                     || o_out_word.door_command == dpo_pkg::CMD_CLOSE)
        else $error("unused door command code");

endmodule

bind door_passage_occupancy_fsm dpo_checker u_dpo_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);
